// ===== rtl/tpp_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tpp_pkg
// Shared types and constants for the triangle plane penalty response block.
// ---------------------------------------------------------------------------
package tpp_pkg;

  localparam int CoordW = 16;
  localparam int RegW   = 48;
  localparam int NrmW   = 35;
  localparam int UnitW  = 31;
  localparam int OutW   = 32;
  localparam int InDataW  = 96;
  localparam int OutDataW = 104;

  localparam logic [RegW-1:0] ThrReset = 48'd167772;

  typedef enum logic [1:0] {
    REG_VERTEX_A  = 2'd0,
    REG_VERTEX_B  = 2'd1,
    REG_VERTEX_C  = 2'd2,
    REG_THRESHOLD = 2'd3
  } reg_idx_t;

  typedef enum logic [2:0] {
    CU_IDLE,
    CU_CROSS,
    CU_MAG,
    CU_SHIFT,
    CU_SQ,
    CU_SUM,
    CU_SQRT,
    CU_DLOAD
  } cu_state_t;

  typedef struct packed {
    logic                        busy;
    logic                        nz;
    logic [2:0][NrmW-1:0]        n;
    logic [2:0][UnitW-1:0]       u;
  } nrm_t;

endpackage

// ===== rtl/tpp_norm_unit.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tpp_norm_unit
// Rebuilds the triangle normal and its Q.30 unit vector after any register
// write: cross product, normalize, bit-serial square root, serial divide.
// ---------------------------------------------------------------------------
module tpp_norm_unit (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         cfg_wr_en,
  input  logic [47:0]  vertex_a,
  input  logic [47:0]  vertex_b,
  input  logic [47:0]  vertex_c,
  output tpp_pkg::nrm_t nrm_o
);

  tpp_pkg::cu_state_t state_r, state_nxt;

  logic signed [16:0] e1 [3];
  logic signed [16:0] e2 [3];
  logic signed [34:0] cr [3];

  logic [2:0][34:0] n_r;
  logic [33:0]      mag_r [3];
  logic [30:0]      magn_r [3];
  logic [61:0]      sq_r [3];
  logic [63:0]      rad_r;
  logic [34:0]      srem_r;
  logic [31:0]      root_r;
  logic [4:0]       scnt_r;
  logic [60:0]      num_r;
  logic [31:0]      drem_r;
  logic [30:0]      dq_r;
  logic [5:0]       dcnt_r;
  logic [1:0]       idx_r;
  logic [2:0][30:0] u_r;

  logic [33:0] mor;
  logic [5:0]  blen;
  logic [34:0] s_tmp, s_trial;
  logic        s_bit;
  logic [32:0] d_tmp;
  logic        d_bit;
  logic        div_run;
  logic        div_done;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      e1[i] = 17'($signed(vertex_b[16*i +: 16])) - 17'($signed(vertex_a[16*i +: 16]));
      e2[i] = 17'($signed(vertex_c[16*i +: 16])) - 17'($signed(vertex_a[16*i +: 16]));
    end
    cr[0] = 35'(e1[1] * e2[2]) - 35'(e1[2] * e2[1]);
    cr[1] = 35'(e1[2] * e2[0]) - 35'(e1[0] * e2[2]);
    cr[2] = 35'(e1[0] * e2[1]) - 35'(e1[1] * e2[0]);
  end

  always_comb begin
    mor  = mag_r[0] | mag_r[1] | mag_r[2];
    blen = '0;
    for (int i = 0; i < 34; i++) begin
      if (mor[i]) begin
        blen = 6'(i + 1);
      end
    end
  end

  always_comb begin
    s_tmp   = {srem_r[32:0], rad_r[63:62]};
    s_trial = {1'b0, root_r, 2'b01};
    s_bit   = (s_tmp >= s_trial);
    d_tmp   = {drem_r, num_r[60]};
    d_bit   = (d_tmp >= {1'b0, root_r});
  end

  // divide runs as a sub-phase of CU_DLOAD tracked by div_run_r
  logic div_run_r;
  assign div_run  = div_run_r;
  assign div_done = div_run_r && (dcnt_r == '0);

  always_comb begin
    state_nxt = state_r;
    if (cfg_wr_en) begin
      state_nxt = tpp_pkg::CU_CROSS;
    end else begin
      unique case (state_r)
        tpp_pkg::CU_IDLE:  state_nxt = tpp_pkg::CU_IDLE;
        tpp_pkg::CU_CROSS: state_nxt = tpp_pkg::CU_MAG;
        tpp_pkg::CU_MAG:   state_nxt = tpp_pkg::CU_SHIFT;
        tpp_pkg::CU_SHIFT: state_nxt = tpp_pkg::CU_SQ;
        tpp_pkg::CU_SQ:    state_nxt = tpp_pkg::CU_SUM;
        tpp_pkg::CU_SUM:   state_nxt = tpp_pkg::CU_SQRT;
        tpp_pkg::CU_SQRT: begin
          if (scnt_r == '0) state_nxt = tpp_pkg::CU_DLOAD;
        end
        tpp_pkg::CU_DLOAD: begin
          if (div_done && idx_r == 2'd2) state_nxt = tpp_pkg::CU_IDLE;
        end
        default: state_nxt = tpp_pkg::CU_CROSS;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= tpp_pkg::CU_CROSS;
      div_run_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_wr_en || state_r != tpp_pkg::CU_DLOAD) begin
        div_run_r <= 1'b0;
      end else if (!div_run_r) begin
        div_run_r <= 1'b1;
      end else if (div_done) begin
        div_run_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      tpp_pkg::CU_IDLE: ;
      tpp_pkg::CU_CROSS: begin
        for (int i = 0; i < 3; i++) n_r[i] <= cr[i];
      end
      tpp_pkg::CU_MAG: begin
        for (int i = 0; i < 3; i++) begin
          mag_r[i] <= n_r[i][34] ? 34'(-$signed(n_r[i])) : n_r[i][33:0];
        end
      end
      tpp_pkg::CU_SHIFT: begin
        for (int i = 0; i < 3; i++) begin
          if (blen > 6'd31) begin
            magn_r[i] <= 31'(mag_r[i] >> (blen - 6'd31));
          end else begin
            magn_r[i] <= 31'(mag_r[i] << (6'd31 - blen));
          end
        end
      end
      tpp_pkg::CU_SQ: begin
        for (int i = 0; i < 3; i++) sq_r[i] <= 62'(magn_r[i] * magn_r[i]);
      end
      tpp_pkg::CU_SUM: begin
        rad_r  <= 64'(sq_r[0]) + 64'(sq_r[1]) + 64'(sq_r[2]);
        srem_r <= '0;
        root_r <= '0;
        scnt_r <= 5'd31;
        idx_r  <= '0;
      end
      tpp_pkg::CU_SQRT: begin
        srem_r <= s_bit ? (s_tmp - s_trial) : s_tmp;
        root_r <= {root_r[30:0], s_bit};
        rad_r  <= {rad_r[61:0], 2'b00};
        scnt_r <= scnt_r - 5'd1;
      end
      tpp_pkg::CU_DLOAD: begin
        if (!div_run) begin
          num_r  <= {magn_r[idx_r], 30'b0};
          drem_r <= '0;
          dq_r   <= '0;
          dcnt_r <= 6'd60;
        end else begin
          drem_r <= d_bit ? 32'(d_tmp - {1'b0, root_r}) : d_tmp[31:0];
          dq_r   <= {dq_r[29:0], d_bit};
          num_r  <= {num_r[59:0], 1'b0};
          dcnt_r <= dcnt_r - 6'd1;
          if (div_done) begin
            u_r[idx_r] <= {dq_r[29:0], d_bit};
            idx_r      <= idx_r + 2'd1;
          end
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    nrm_o.busy = (state_r != tpp_pkg::CU_IDLE);
    nrm_o.nz   = (n_r[0] != '0) || (n_r[1] != '0) || (n_r[2] != '0);
    nrm_o.n    = n_r;
    nrm_o.u    = u_r;
  end

endmodule

// ===== rtl/triangle_plane_penalty_response.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// triangle_plane_penalty_response
// Penalty response of one particle against a triangle held in registers.
// ---------------------------------------------------------------------------
// Throughput: one transaction per cycle through the seven-stage datapath;
// a stalled output freezes all stages. After reset and after every register
// write the normal unit rebuilds the unit normal (32-step square root, three
// divides); in_tready stays low meanwhile. Reset is synchronous, active low.
module triangle_plane_penalty_response (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          cfg_wr_en,
  input  logic [1:0]    cfg_index,
  input  logic [47:0]   cfg_data,
  input  logic          in_tvalid,
  output logic          in_tready,
  // pos_x, pos_y, pos_z, vel_x, vel_y, vel_z
  input  logic [95:0]   in_tdata,
  output logic          out_tvalid,
  input  logic          out_tready,
  // resp_x, resp_y, resp_z, in_contact, saturated, zero pad
  output logic [103:0]  out_tdata
);

  logic [47:0] va_r, vb_r, vc_r, thr_r;
  tpp_pkg::nrm_t nrm;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r  <= '0;
      vb_r  <= '0;
      vc_r  <= '0;
      thr_r <= tpp_pkg::ThrReset;
    end else if (cfg_wr_en) begin
      unique case (tpp_pkg::reg_idx_t'(cfg_index))
        tpp_pkg::REG_VERTEX_A:  va_r  <= cfg_data;
        tpp_pkg::REG_VERTEX_B:  vb_r  <= cfg_data;
        tpp_pkg::REG_VERTEX_C:  vc_r  <= cfg_data;
        tpp_pkg::REG_THRESHOLD: thr_r <= cfg_data;
        default: ;
      endcase
    end
  end

  tpp_norm_unit u_norm (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .vertex_a  (va_r),
    .vertex_b  (vb_r),
    .vertex_c  (vc_r),
    .nrm_o     (nrm)
  );

  logic en, acc;
  logic [7:1] v_r;

  logic signed [16:0] p1_dif_r [3];
  logic signed [15:0] p1_vel_r [3];
  logic signed [51:0] p2_dp_r [3];
  logic signed [50:0] p2_vp_r [3];
  logic signed [53:0] p3_d_r;
  logic signed [52:0] p3_pv_r;
  logic [56:0]        p4_qm_r;
  logic               p4_qneg_r, p4_ct_r;
  logic [59:0]        p5_pl_r [3];
  logic [58:0]        p5_ph_r [3];
  logic               p5_qneg_r, p5_ct_r;
  logic [41:0]        p6_m_r [3];
  logic [2:0]         p6_neg_r;
  logic               p6_ct_r;
  logic [31:0]        resp_r [3];
  logic               ct_r, sat_r;

  logic signed [57:0] q;
  logic [87:0]        full [3];
  logic [41:0]        lim [3];
  logic [41:0]        mc [3];
  logic [31:0]        rv [3];
  logic [2:0]         clip;

  assign en        = !v_r[7] || out_tready;
  assign in_tready = en && !nrm.busy;
  assign acc       = in_tvalid && in_tready;
  assign out_tvalid = v_r[7];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[6:1], acc};
    end
  end

  always_comb begin
    q = (58'(p3_pv_r) <<< 4) + (58'(p3_pv_r) <<< 2);
    for (int i = 0; i < 3; i++) begin
      full[i] = {p5_ph_r[i], 29'b0} + 88'(p5_pl_r[i]);
      lim[i]  = p6_neg_r[i] ? 42'h0_8000_0000 : 42'h0_7FFF_FFFF;
      clip[i] = p6_m_r[i] > lim[i];
      mc[i]   = clip[i] ? lim[i] : p6_m_r[i];
      rv[i]   = p6_neg_r[i] ? (32'd0 - mc[i][31:0]) : mc[i][31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        p1_dif_r[i] <= 17'($signed(va_r[16*i +: 16])) - 17'($signed(in_tdata[16*i +: 16]));
        p1_vel_r[i] <= $signed(in_tdata[48 + 16*i +: 16]);
        p2_dp_r[i]  <= 52'(p1_dif_r[i] * $signed(nrm.n[i]));
        p2_vp_r[i]  <= 51'(p1_vel_r[i] * $signed(nrm.n[i]));
        p5_pl_r[i]  <= 60'(p4_qm_r[28:0] * nrm.u[i]);
        p5_ph_r[i]  <= 59'(p4_qm_r[56:29] * nrm.u[i]);
        p6_m_r[i]   <= full[i][87:46];
        p6_neg_r[i] <= p5_qneg_r ^ nrm.n[i][34];
        resp_r[i]   <= p6_ct_r ? rv[i] : 32'd0;
      end
      p3_d_r    <= 54'(p2_dp_r[0]) + 54'(p2_dp_r[1]) + 54'(p2_dp_r[2]);
      p3_pv_r   <= 53'(p2_vp_r[0]) + 53'(p2_vp_r[1]) + 53'(p2_vp_r[2]);
      p4_qneg_r <= q[57];
      p4_qm_r   <= q[57] ? 57'(-q) : q[56:0];
      p4_ct_r   <= nrm.nz && !(p3_d_r > $signed(thr_r));
      p5_qneg_r <= p4_qneg_r;
      p5_ct_r   <= p4_ct_r;
      p6_ct_r   <= p5_ct_r;
      ct_r      <= p6_ct_r;
      sat_r     <= p6_ct_r && (clip != '0);
    end
  end

  assign out_tdata = {6'b0, sat_r, ct_r, resp_r[2], resp_r[1], resp_r[0]};

endmodule
